// File: rtl/core/bfes_pkg.sv
// Shared types, constants and helper functions for the bitmap free-extent scanner.
package bfes_pkg;

    // Upper bound on the number of bitmap bits examined, whatever bits_in_group says
    localparam int MAX_GROUP_BITS = 32768;

    // Word queue between front and back end (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BITS_IN_GROUP = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_TAG     = 1'b1;

    localparam logic [15:0] BITS_IN_GROUP_RESET = 16'd32768;
    localparam logic [31:0] GROUP_TAG_RESET     = 32'd0;

    // One classified bitmap byte: run starts and run ends, plus scan state at entry.
    // ends[c] means a run finishes just before bit c (bit 8 = past the byte).
    typedef struct packed {
        logic [15:0] pos;
        logic [14:0] carry_start;
        logic [15:0] carry_len;
        logic [14:0] runs_base;
        logic [7:0]  starts;
        logic [8:0]  ends;
    } bfes_entry_t;

    // Entry with its valid flag (push side and head side of the queue)
    typedef struct packed {
        logic        valid;
        bfes_entry_t entry;
    } bfes_slot_t;

    // Number of set bits in a 9-bit vector
    function automatic logic [3:0] ones9(input logic [8:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 9; i++)
            n = n + 4'(v[i]);
        return n;
    endfunction

    // Index of the highest set bit of an 8-bit vector (0 when empty)
    function automatic logic [2:0] msb8(input logic [7:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = 0; i < 8; i++)
            if (v[i])
                idx = 3'(i);
        return idx;
    endfunction

    // Index of the lowest set bit of a 9-bit vector (0 when empty)
    function automatic logic [3:0] lsb9(input logic [8:0] v);
        logic [3:0] idx;
        idx = '0;
        for (int i = 8; i >= 0; i--)
            if (v[i])
                idx = 4'(i);
        return idx;
    endfunction

endpackage

// File: rtl/core/bfes_if.sv
// Channel interfaces: bitmap byte input and extent result output.
interface bfes_byte_if
    import bfes_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] bitmap_byte;
    logic       end_of_bitmap;

    modport source (output valid, output bitmap_byte, output end_of_bitmap, input ready);
    modport sink   (input valid, input bitmap_byte, input end_of_bitmap, output ready);
endinterface

interface bfes_extent_if
    import bfes_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [31:0] extent_group;
    logic [14:0] extent_start;
    logic [15:0] extent_length;
    logic [14:0] extent_index;
    logic        last_of_item;

    modport source (output valid, output extent_group, output extent_start,
                    output extent_length, output extent_index, output last_of_item,
                    input ready);
    modport sink   (input valid, input extent_group, input extent_start,
                    input extent_length, input extent_index, input last_of_item,
                    output ready);
endinterface

// File: rtl/core/bfes_front.sv
// Front end: takes bitmap bytes, tracks the open free run and classifies run ends.
module bfes_front
    import bfes_pkg::*;
#(
    parameter int GROUP_BITS_MAX = MAX_GROUP_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    bfes_byte_if.sink         bitmap_in,
    input  logic [15:0]       bits_in_group,
    input  logic              full,
    output bfes_slot_t        push
);

    logic [15:0] pos_reg,       pos_next;
    logic        in_run_reg,    in_run_next;
    logic [14:0] run_start_reg, run_start_next;
    logic [15:0] run_len_reg,   run_len_next;
    logic [14:0] runs_reg,      runs_next;

    logic [15:0] limit;
    logic [15:0] span;
    logic [3:0]  n_valid;
    logic [7:0]  vmask;
    logic [7:0]  free_bits;
    logic [7:0]  used_bits;
    logic [7:0]  prev_free;
    logic [7:0]  starts;
    logic [7:0]  ends_used;
    logic [8:0]  ends;
    logic        run_at_end;
    logic        flush;
    logic        any_start;
    logic [2:0]  s_hi;
    logic        accept;

    assign bitmap_in.ready = !full;
    assign accept          = bitmap_in.valid && !full;

    // Effective limit and number of bits of this byte still inside it
    always_comb
    begin
        limit = (32'(bits_in_group) > GROUP_BITS_MAX) ? 16'(GROUP_BITS_MAX) : bits_in_group;
        span  = limit - pos_reg;
        if (pos_reg >= limit)
            n_valid = 4'd0;
        else if (span >= 16'd8)
            n_valid = 4'd8;
        else
            n_valid = span[3:0];
    end

    // Per-bit classification: run starts and used bits that close a run
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            vmask[b]     = 4'(b) < n_valid;
            free_bits[b] = !bitmap_in.bitmap_byte[b] && vmask[b];
            used_bits[b] = bitmap_in.bitmap_byte[b] && vmask[b];
        end
        prev_free[0] = in_run_reg;
        for (int b = 1; b < 8; b++)
            prev_free[b] = free_bits[b-1];
        starts    = free_bits & ~prev_free;
        ends_used = used_bits & prev_free;

        run_at_end = (n_valid == 4'd0) ? in_run_reg : free_bits[3'(n_valid - 4'd1)];
        flush      = bitmap_in.end_of_bitmap && run_at_end;
        ends       = {1'b0, ends_used} | (flush ? (9'b1 << n_valid) : 9'b0);
        any_start  = |starts;
        s_hi       = msb8(starts);
    end

    // Scan state after this byte
    always_comb
    begin
        pos_next       = pos_reg;
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        runs_next      = runs_reg;
        if (accept)
        begin
            if (bitmap_in.end_of_bitmap)
            begin
                pos_next       = '0;
                in_run_next    = 1'b0;
                run_start_next = '0;
                run_len_next   = '0;
                runs_next      = '0;
            end
            else
            begin
                pos_next    = pos_reg + 16'(n_valid);
                in_run_next = run_at_end;
                runs_next   = runs_reg + 15'(ones9(ends));
                if (run_at_end)
                begin
                    if (any_start)
                    begin
                        run_start_next = pos_reg[14:0] + 15'(s_hi);
                        run_len_next   = 16'(n_valid) - 16'(s_hi);
                    end
                    else
                    begin
                        run_len_next = run_len_reg + 16'(n_valid);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            in_run_reg    <= 1'b0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            runs_reg      <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            in_run_reg    <= in_run_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            runs_reg      <= runs_next;
        end
    end

    // Only bytes that finish at least one run go to the back end
    always_comb
    begin
        push.valid             = accept && (|ends);
        push.entry.pos         = pos_reg;
        push.entry.carry_start = run_start_reg;
        push.entry.carry_len   = run_len_reg;
        push.entry.runs_base   = runs_reg;
        push.entry.starts      = starts;
        push.entry.ends        = ends;
    end

endmodule

// File: rtl/core/bfes_queue.sv
// Small FIFO of classified bytes between front and back end.
module bfes_queue
    import bfes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bfes_slot_t push,
    input  logic       pop,
    output logic       full,
    output bfes_slot_t head
);

    bfes_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = mem_reg[rd_ptr_reg];

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push.valid && !pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop && !push.valid)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

// File: rtl/core/bfes_back.sv
// Back end: walks the run ends of the head entry, one extent word per cycle while the receiver takes them.
module bfes_back
    import bfes_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bfes_slot_t    head,
    input  logic [31:0]   group_tag,
    output logic          pop,
    bfes_extent_if.source extent_out
);

    logic [8:0]  done_reg;
    logic [2:0]  k_reg;
    logic        out_valid_reg;
    logic [31:0] group_reg;
    logic [14:0] start_reg;
    logic [15:0] length_reg;
    logic [14:0] index_reg;
    logic        last_reg;

    logic [8:0]  remaining;
    logic [3:0]  c;
    logic [8:0]  c_hot;
    logic [8:0]  below;
    logic [7:0]  starts_below;
    logic        has_start;
    logic [2:0]  s;
    logic        is_last;
    logic [14:0] start_val;
    logic [15:0] length_val;
    logic        load;

    // Next run end and the start that opened it
    always_comb
    begin
        remaining    = head.entry.ends & ~done_reg;
        c            = lsb9(remaining);
        c_hot        = 9'b1 << c;
        below        = c_hot - 9'd1;
        is_last      = (remaining & ~c_hot) == 9'b0;
        starts_below = head.entry.starts & below[7:0];
        has_start    = |starts_below;
        s            = msb8(starts_below);
        if (has_start)
        begin
            start_val  = head.entry.pos[14:0] + 15'(s);
            length_val = 16'(c) - 16'(s);
        end
        else
        begin
            start_val  = head.entry.carry_start;
            length_val = head.entry.carry_len + 16'(c);
        end
    end

    assign load = head.valid && (!out_valid_reg || extent_out.ready);
    assign pop  = load && is_last;

    // Walk state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            done_reg      <= is_last ? 9'b0 : (done_reg | c_hot);
            k_reg         <= is_last ? 3'd0 : (k_reg + 3'd1);
            out_valid_reg <= 1'b1;
        end
        else if (extent_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            group_reg  <= group_tag;
            start_reg  <= start_val;
            length_reg <= length_val;
            index_reg  <= head.entry.runs_base + 15'(k_reg);
            last_reg   <= is_last;
        end
    end

    assign extent_out.valid         = out_valid_reg;
    assign extent_out.extent_group  = group_reg;
    assign extent_out.extent_start  = start_reg;
    assign extent_out.extent_length = length_reg;
    assign extent_out.extent_index  = index_reg;
    assign extent_out.last_of_item  = last_reg;

endmodule

// File: rtl/core/bitmap_free_extent_scan.sv
// Top level of the bitmap free-extent scanner: config registers and front/queue/back.
//
//  channel     dir  handshake            payload
//  bitmap_in   in   valid/ready          bitmap_byte[7:0], end_of_bitmap
//  extent_out  out  valid/ready          extent_group, extent_start, extent_length,
//                                        extent_index, last_of_item
//  cfg         in   cfg_we (no stall)    cfg_index[0:0], cfg_wdata[31:0]
//
// A byte is taken every cycle while the 4-entry queue has room; the front end
// classifies it in the cycle it is taken. Extent words leave the back end one per
// cycle while the receiver takes them, so a byte that finishes n runs (n is at
// most 5) holds the back end for n words. Results pass the queue, then the output register.
// Reset loads the config defaults and empties the queue; no clearing pass.
// Either side may stall; the queue and output register keep the other side moving.
module bitmap_free_extent_scan
    import bfes_pkg::*;
#(
    parameter int GROUP_BITS_MAX = MAX_GROUP_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    bfes_byte_if.sink              bitmap_in,
    bfes_extent_if.source          extent_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_wdata
);

    logic [15:0] bits_in_group_reg;
    logic [31:0] group_tag_reg;

    bfes_slot_t  push;
    bfes_slot_t  head;
    logic        full;
    logic        pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_group_reg <= BITS_IN_GROUP_RESET;
            group_tag_reg     <= GROUP_TAG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BITS_IN_GROUP: bits_in_group_reg <= cfg_wdata[15:0];
                CFG_GROUP_TAG:     group_tag_reg     <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    bfes_front #(
        .GROUP_BITS_MAX (GROUP_BITS_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .bitmap_in     (bitmap_in),
        .bits_in_group (bits_in_group_reg),
        .full          (full),
        .push          (push)
    );

    bfes_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    bfes_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .group_tag  (group_tag_reg),
        .pop        (pop),
        .extent_out (extent_out)
    );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the bitmap free-extent scanner.
module tb_top
    import bfes_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 380;
    localparam int SETTLE       = 8;

    typedef enum int {FILL_RANDOM, FILL_SPARSE, FILL_DENSE, FILL_FREE, FILL_STRIPED} fill_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_STALLS, RX_MOSTLY} rx_mode_t;

    // One expected or observed extent word
    typedef struct packed {
        logic [31:0] grp;
        logic [14:0] start_pos;
        logic [15:0] len;
        logic [14:0] ordinal;
        logic        last_one;
    } extent_t;

    // Scan-state mirror and queue of extents still owed by the block
    class extent_scoreboard;
        logic [15:0] bits_in_group;
        logic [31:0] group_tag;
        logic [15:0] scan_pos;
        logic        in_run;
        logic [14:0] run_start;
        logic [15:0] run_len;
        logic [14:0] run_count;
        extent_t     owed_extents[$];
        int          checked;

        function new();
            bits_in_group = BITS_IN_GROUP_RESET;
            group_tag     = GROUP_TAG_RESET;
            scan_pos      = '0;
            in_run        = 1'b0;
            run_start     = '0;
            run_len       = '0;
            run_count     = '0;
            checked       = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
            if (idx == CFG_BITS_IN_GROUP)
                bits_in_group = v[15:0];
            else if (idx == CFG_GROUP_TAG)
                group_tag = v;
        endfunction

        function extent_t close_run();
            extent_t e;
            e.grp       = group_tag;
            e.start_pos = run_start;
            e.len       = run_len;
            e.ordinal   = run_count;
            e.last_one  = 1'b0;
            run_count   = run_count + 15'd1;
            return e;
        endfunction

        // Walk the accepted byte bit by bit and queue every run it finishes
        function void note_byte(logic [7:0] b, logic eob);
            extent_t batch[5];
            int      n;
            int      lim;
            n   = 0;
            lim = bits_in_group;
            if (lim > MAX_GROUP_BITS)
                lim = MAX_GROUP_BITS;
            for (int k = 0; k < 8; k++)
            begin
                if (scan_pos >= lim)
                    break;
                if (b[k])
                begin
                    if (in_run)
                    begin
                        batch[n] = close_run();
                        n++;
                    end
                    in_run = 1'b0;
                end
                else
                begin
                    if (!in_run)
                    begin
                        run_start = scan_pos[14:0];
                        run_len   = '0;
                    end
                    run_len = run_len + 16'd1;
                    in_run  = 1'b1;
                end
                scan_pos = scan_pos + 16'd1;
            end
            // end of bitmap: flush an open run, then clear the scan
            if (eob)
            begin
                if (in_run)
                begin
                    batch[n] = close_run();
                    n++;
                end
                scan_pos  = '0;
                in_run    = 1'b0;
                run_start = '0;
                run_len   = '0;
                run_count = '0;
            end
            if (n > 0)
                batch[n-1].last_one = 1'b1;
            for (int k = 0; k < n; k++)
                owed_extents.push_back(batch[k]);
        endfunction

        // Empty string when the word matches the oldest owed extent
        function string check_extent(extent_t got);
            extent_t want;
            string   msg;
            msg = "";
            if (owed_extents.size() == 0)
                return $sformatf("extent word with none owed: start %0d len %0d index %0d",
                                 got.start_pos, got.len, got.ordinal);
            want = owed_extents.pop_front();
            checked++;
            if (got.grp != want.grp)
                msg = {msg, $sformatf(" group %h/%h", got.grp, want.grp)};
            if (got.start_pos != want.start_pos)
                msg = {msg, $sformatf(" start %0d/%0d", got.start_pos, want.start_pos)};
            if (got.len != want.len)
                msg = {msg, $sformatf(" length %0d/%0d", got.len, want.len)};
            if (got.ordinal != want.ordinal)
                msg = {msg, $sformatf(" index %0d/%0d", got.ordinal, want.ordinal)};
            if (got.last_one != want.last_one)
                msg = {msg, $sformatf(" last %0b/%0b", got.last_one, want.last_one)};
            if (msg != "")
                msg = {$sformatf("extent #%0d got/want:", checked), msg};
            return msg;
        endfunction

        function int owed();
            return owed_extents.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_wdata;

    bfes_byte_if   byte_ch();
    bfes_extent_if ext_ch();

    bitmap_free_extent_scan dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .bitmap_in  (byte_ch),
        .extent_out (ext_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    extent_scoreboard sb;
    int      errors      = 0;
    int      bytes_sent  = 0;
    int      scans_sent  = 0;
    int      burst_left  = 0;
    int      cycle_count = 0;
    extent_t mon_word;
    string   mon_msg;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH: %s", msg);
    endtask

    // Present one byte, bursts broken by random gaps; note it when taken
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                byte_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        byte_ch.valid         <= 1'b1;
        byte_ch.bitmap_byte   <= b;
        byte_ch.end_of_bitmap <= eob;
        do @(posedge clk); while (!byte_ch.ready);
        sb.note_byte(b, eob);
        bytes_sent++;
        if (eob)
            scans_sent++;
    endtask

    // Drop valid and wait until every owed extent has come out
    task automatic drain();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write both registers back to back; only called with the block idle
    task automatic set_config(input logic [15:0] bits, input logic [31:0] tag);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BITS_IN_GROUP;
        cfg_wdata <= {16'h0, bits};
        @(posedge clk);
        sb.set_reg(CFG_BITS_IN_GROUP, {16'h0, bits});
        @(negedge clk);
        cfg_index <= CFG_GROUP_TAG;
        cfg_wdata <= tag;
        @(posedge clk);
        sb.set_reg(CFG_GROUP_TAG, tag);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte(input fill_t style);
        logic [7:0] b;
        case (style)
            FILL_SPARSE:
                for (int k = 0; k < 8; k++) b[k] = ($urandom_range(0, 7) == 0);
            FILL_DENSE:
                for (int k = 0; k < 8; k++) b[k] = ($urandom_range(0, 7) != 0);
            FILL_FREE:
                b = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00;
            FILL_STRIPED:
                b = ($urandom_range(0, 1) == 0) ? 8'h55 : 8'hAA;
            default:
                b = 8'($urandom);
        endcase
        return b;
    endfunction

    // Receiver: ready changes at the falling edge in modes of random length
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold;
        mode      = RX_OPEN;
        mode_left = 0;
        hold      = 0;
        ext_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
                RX_OPEN:
                    ext_ch.ready <= 1'b1;
                RX_COIN:
                    ext_ch.ready <= 1'($urandom_range(0, 1));
                RX_STALLS:
                    if (hold > 0)
                    begin
                        hold--;
                        ext_ch.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        hold = $urandom_range(1, 12);
                        ext_ch.ready <= 1'b0;
                    end
                    else
                        ext_ch.ready <= 1'b1;
                default:
                    ext_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Result monitor: check each word taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && ext_ch.valid && ext_ch.ready)
        begin
            mon_word.grp       = ext_ch.extent_group;
            mon_word.start_pos = ext_ch.extent_start;
            mon_word.len       = ext_ch.extent_length;
            mon_word.ordinal   = ext_ch.extent_index;
            mon_word.last_one  = ext_ch.last_of_item;
            mon_msg = sb.check_extent(mon_word);
            if (mon_msg != "")
                report_mismatch(mon_msg);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        int          rand_bytes;
        int          nbytes;
        int          sel;
        bit          keep_open;
        logic        eob;
        logic [15:0] lim;
        logic [31:0] tag;
        fill_t       style;

        sb = new();
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_BITS_IN_GROUP;
        cfg_wdata             = '0;
        byte_ch.valid         = 1'b0;
        byte_ch.bitmap_byte   = '0;
        byte_ch.end_of_bitmap = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: full group, five extents from one byte, empty and full bytes
        set_config(16'h8000, 32'h0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b1);
        drain();

        // Short group: run reaches the limit, bytes past it ignored
        set_config(16'd13, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
        drain();

        // Tag changed mid-scan: the open run leaves with the new tag
        set_config(16'd13, 32'hA5A5_5A5A);
        send_byte(8'h00, 1'b1);
        drain();

        // One-bit group, then a zero-bit group where no run forms
        set_config(16'd1, 32'h0000_0001);
        send_byte(8'hFE, 1'b1);
        drain();
        set_config(16'd0, 32'h8000_0001);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        // Random scans: mostly well-formed bitmaps, some left open, some cut short
        rand_bytes = 0;
        while (rand_bytes < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                lim = 16'($urandom_range(1, 64));
            else if (sel < 9)
                lim = 16'($urandom_range(65, 400));
            else
            begin
                case ($urandom_range(0, 4))
                    0: lim = 16'd1;
                    1: lim = 16'd8;
                    2: lim = 16'd9;
                    3: lim = 16'd32767;
                    default: lim = 16'h8000;
                endcase
            end
            case ($urandom_range(0, 7))
                0: tag = 32'h0;
                1: tag = 32'hFFFF_FFFF;
                default: tag = $urandom;
            endcase
            set_config(lim, tag);

            nbytes = (int'(lim) + 7) / 8 + $urandom_range(0, 2);
            if (nbytes > 48)
                nbytes = $urandom_range(20, 48);
            keep_open = ($urandom_range(0, 7) == 0);
            style = fill_t'($urandom_range(0, 4));
            for (int k = 0; k < nbytes; k++)
            begin
                eob = ((k == nbytes - 1) && !keep_open) || ($urandom_range(0, 49) == 0);
                send_byte(pick_byte(style), eob);
                rand_bytes++;
                if ($urandom_range(0, 5) == 0)
                    style = fill_t'($urandom_range(0, 4));
            end
            drain();
        end

        $display("summary: %0d bitmap bytes over %0d scans, %0d extent words checked",
                 bytes_sent, scans_sent, sb.checked);
        $display("summary: group sizes from 0 to 32768 bits, open runs across config writes");
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: bitmap_free_extent_scan.f
rtl/core/bfes_pkg.sv
rtl/core/bfes_if.sv
rtl/core/bfes_front.sv
rtl/core/bfes_queue.sv
rtl/core/bfes_back.sv
rtl/core/bitmap_free_extent_scan.sv
test/tb_top.sv
